// ===== hw/rtl/rbsf_pkg.sv =====
`timescale 1ns / 1ps

package rbsf_pkg;

  // Window and ring geometry
  localparam int KeyMax   = 32;
  localparam int KeySelW  = $clog2(KeyMax);
  localparam int KeyLenW  = 6;
  localparam int BufDepth = 4096;
  localparam int IdxW     = 12;
  localparam int LenW     = 13;
  localparam int BackW    = KeySelW;
  localparam int DataW    = 8;

  // Configuration port
  localparam int AddrW  = 6;
  localparam int PDataW = 64;
  localparam int RegSelW = 3;
  localparam int KeyWords = 4;

  // Register indexes (byte address / 8)
  localparam logic [RegSelW-1:0] RegKeyLen    = 3'd0;
  localparam logic [RegSelW-1:0] RegKeyLow    = 3'd1;
  localparam logic [RegSelW-1:0] RegKeySecond = 3'd2;
  localparam logic [RegSelW-1:0] RegKeyThird  = 3'd3;
  localparam logic [RegSelW-1:0] RegKeyHigh   = 3'd4;
  localparam logic [RegSelW-1:0] RegBufSize   = 3'd5;

  // Window cell control
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // Result request into the index wrap pipeline
  typedef struct packed {
    logic              found;
    logic [IdxW-1:0]   index;
    logic [BackW-1:0]  back;
  } wrap_req_t;

endpackage

// ===== hw/rtl/rbsf_if.sv =====
`timescale 1ns / 1ps

// Byte stream channel
interface rbsf_in_if;
  logic                         valid;
  logic                         ready;
  logic [rbsf_pkg::DataW-1:0]   data_byte;
  logic [rbsf_pkg::IdxW-1:0]    byte_index;
  logic                         byte_valid;
  logic                         end_of_data;

  modport source (output valid, data_byte, byte_index, byte_valid, end_of_data,
                  input ready);
  modport sink (input valid, data_byte, byte_index, byte_valid, end_of_data,
                output ready);
endinterface

// Search result channel
interface rbsf_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [rbsf_pkg::IdxW-1:0]   match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink (input valid, found, match_index, output ready);
endinterface

// ===== hw/rtl/rbsf_cell.sv =====
`timescale 1ns / 1ps

module rbsf_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  rbsf_pkg::cell_ctrl_t        ctrl,
  input  logic                        in_valid,
  input  logic [rbsf_pkg::DataW-1:0]  in_byte,
  input  logic [rbsf_pkg::DataW-1:0]  key_byte,
  input  logic                        en,
  output logic                        out_valid,
  output logic [rbsf_pkg::DataW-1:0]  out_byte,
  output logic                        hit
);

  // Occupancy of this window slot; clear wins over shift
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.clear) begin
      out_valid <= 1'b0;
    end else if (ctrl.shift) begin
      out_valid <= in_valid;
    end
  end

  // Byte held by this slot
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      out_byte <= in_byte;
    end
  end

  // Compare the byte that moves in now; slots beyond the key always agree
  assign hit = !en || (in_valid && (in_byte == key_byte));

endmodule

// ===== hw/rtl/rbsf_wrap.sv =====
`timescale 1ns / 1ps

module rbsf_wrap (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  rbsf_pkg::wrap_req_t         req,
  input  logic [rbsf_pkg::LenW-1:0]   buf_len,
  output logic                        ready,
  rbsf_out_if.source                  result
);

  localparam int NStage = rbsf_pkg::IdxW + 1;
  localparam int Last   = NStage - 1;
  localparam int WideW  = rbsf_pkg::LenW + rbsf_pkg::IdxW;

  logic                          v   [NStage];
  logic                          fnd [NStage];
  logic [rbsf_pkg::IdxW-1:0]     r   [NStage];
  logic [rbsf_pkg::BackW-1:0]    bk  [NStage];

  logic                          rdy    [NStage];
  logic                          p_v    [NStage];
  logic                          p_f    [NStage];
  logic [rbsf_pkg::IdxW-1:0]     p_r    [NStage];
  logic [rbsf_pkg::BackW-1:0]    p_b    [NStage];
  logic [rbsf_pkg::IdxW-1:0]     r_next [NStage];
  logic [rbsf_pkg::BackW-1:0]    b_next [NStage];

  logic [WideW-1:0]              sh     [rbsf_pkg::IdxW];
  logic [rbsf_pkg::LenW-1:0]     sum;
  logic [rbsf_pkg::LenW-1:0]     wrapped;

  // Stage ready chain: a stage takes a new item if empty or draining
  always_comb begin
    rdy[Last] = !v[Last] || result.ready;
    for (int s = Last - 1; s >= 0; s--) begin
      rdy[s] = !v[s] || rdy[s+1];
    end
  end

  assign ready = rdy[0];

  // Inputs to each stage
  always_comb begin
    p_v[0] = push;
    p_f[0] = req.found;
    p_r[0] = req.index;
    p_b[0] = req.back;
    for (int s = 1; s < NStage; s++) begin
      p_v[s] = v[s-1];
      p_f[s] = fnd[s-1];
      p_r[s] = r[s-1];
      p_b[s] = bk[s-1];
    end
  end

  // One restoring step per stage reduces both index and back offset
  always_comb begin
    for (int s = 0; s < rbsf_pkg::IdxW; s++) begin
      sh[s] = WideW'(buf_len) << (rbsf_pkg::IdxW - 1 - s);
      if (WideW'(p_r[s]) >= sh[s]) begin
        r_next[s] = p_r[s] - sh[s][rbsf_pkg::IdxW-1:0];
      end else begin
        r_next[s] = p_r[s];
      end
      if (WideW'(p_b[s]) >= sh[s]) begin
        b_next[s] = p_b[s] - sh[s][rbsf_pkg::BackW-1:0];
      end else begin
        b_next[s] = p_b[s];
      end
    end
    // Final stage: step back from the last byte, wrap once
    sum = rbsf_pkg::LenW'(p_r[Last]) + buf_len - rbsf_pkg::LenW'(p_b[Last]);
    if (sum >= buf_len) begin
      wrapped = sum - buf_len;
    end else begin
      wrapped = sum;
    end
    r_next[Last] = p_f[Last] ? wrapped[rbsf_pkg::IdxW-1:0] : '0;
    b_next[Last] = p_b[Last];
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NStage; s++) begin
        v[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s < NStage; s++) begin
        if (rdy[s]) begin
          v[s] <= p_v[s];
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    for (int s = 0; s < NStage; s++) begin
      if (rdy[s]) begin
        fnd[s] <= p_f[s];
        r[s]   <= r_next[s];
        bk[s]  <= b_next[s];
      end
    end
  end

  assign result.valid       = v[Last];
  assign result.found       = fnd[Last];
  assign result.match_index = r[Last];

  // Not-found results carry a zero index
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.found |-> result.match_index == '0)
    else $error("not-found result with nonzero index");

  // Found index lies inside the ring
  a_in_ring: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.found |-> {1'b0, result.match_index} < buf_len)
    else $error("match index outside ring");

  // Only output backpressure can stall the input
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !ready |-> result.valid && !result.ready)
    else $error("pipeline stalled without output backpressure");

endmodule

// ===== hw/rtl/ring_buffer_substring_find.sv =====
`timescale 1ns / 1ps

// Finds the first occurrence of a key (1 to 32 bytes) in a byte stream read
// from a ring buffer. One item is accepted every cycle unless the result
// output stalls; the window shift and the compare against all key bytes happen
// in the accepting cycle across a row of 32 byte cells. A result (found with
// the start index, or not-found on the end item) goes out through the
// pipelined start-index wrap, which does one restoring step of the modulo per stage.
// Bytes after a match are ignored until the end item, which rearms the search.
// Registers sit at byte address 8*i: key_len, four 64-bit key words (byte 0
// in the low bits), buffer_size (0 or above 4096 acts as 4096).
module ring_buffer_substring_find (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbsf_pkg::AddrW-1:0]    paddr,
  input  logic [rbsf_pkg::PDataW-1:0]   pwdata,
  output logic [rbsf_pkg::PDataW-1:0]   prdata,
  output logic                          pready,
  rbsf_in_if.sink                       stream,
  rbsf_out_if.source                    result
);

  localparam int KeyMax = rbsf_pkg::KeyMax;

  logic [rbsf_pkg::KeyLenW-1:0]  key_len;
  logic [rbsf_pkg::PDataW-1:0]   key_word [rbsf_pkg::KeyWords];
  logic [rbsf_pkg::LenW-1:0]     buffer_size;
  logic [rbsf_pkg::RegSelW-1:0]  reg_sel;
  logic                          cfg_wr;

  logic [rbsf_pkg::DataW-1:0]    key_byte    [KeyMax];
  logic [rbsf_pkg::DataW-1:0]    aligned_key [KeyMax];
  logic [rbsf_pkg::KeyLenW-1:0]  key_pos     [KeyMax];
  logic                          cell_en     [KeyMax];
  logic                          cell_v      [KeyMax];
  logic [rbsf_pkg::DataW-1:0]    cell_b      [KeyMax];
  logic [KeyMax-1:0]             hit;

  rbsf_pkg::cell_ctrl_t          ctrl;
  rbsf_pkg::wrap_req_t           req;
  logic                          search_done;
  logic                          accept;
  logic                          take;
  logic                          end_hit;
  logic                          key_ok;
  logic                          match;
  logic                          push;
  logic                          wrap_ready;
  logic [rbsf_pkg::LenW-1:0]     buf_len;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[rbsf_pkg::AddrW-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_len     <= '0;
      buffer_size <= rbsf_pkg::LenW'(rbsf_pkg::BufDepth);
      for (int w = 0; w < rbsf_pkg::KeyWords; w++) begin
        key_word[w] <= '0;
      end
    end else if (cfg_wr) begin
      case (reg_sel)
        rbsf_pkg::RegKeyLen:    key_len     <= pwdata[rbsf_pkg::KeyLenW-1:0];
        rbsf_pkg::RegKeyLow:    key_word[0] <= pwdata;
        rbsf_pkg::RegKeySecond: key_word[1] <= pwdata;
        rbsf_pkg::RegKeyThird:  key_word[2] <= pwdata;
        rbsf_pkg::RegKeyHigh:   key_word[3] <= pwdata;
        rbsf_pkg::RegBufSize:   buffer_size <= pwdata[rbsf_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_sel)
      rbsf_pkg::RegKeyLen:    prdata = rbsf_pkg::PDataW'(key_len);
      rbsf_pkg::RegKeyLow:    prdata = key_word[0];
      rbsf_pkg::RegKeySecond: prdata = key_word[1];
      rbsf_pkg::RegKeyThird:  prdata = key_word[2];
      rbsf_pkg::RegKeyHigh:   prdata = key_word[3];
      rbsf_pkg::RegBufSize:   prdata = rbsf_pkg::PDataW'(buffer_size);
      default:                prdata = '0;
    endcase
  end

  // Key bytes aligned to window slots: slot j (newest first) meets key byte
  // key_len-1-j
  always_comb begin
    for (int i = 0; i < KeyMax; i++) begin
      key_byte[i] = key_word[i / 8][(i % 8) * 8 +: 8];
    end
    for (int j = 0; j < KeyMax; j++) begin
      key_pos[j]     = key_len - rbsf_pkg::KeyLenW'(1) - rbsf_pkg::KeyLenW'(j);
      aligned_key[j] = key_byte[key_pos[j][rbsf_pkg::KeySelW-1:0]];
      cell_en[j]     = key_len > rbsf_pkg::KeyLenW'(j);
    end
  end

  // Item handling
  assign accept  = stream.valid && stream.ready;
  assign take    = accept && stream.byte_valid && !search_done;
  assign end_hit = accept && stream.end_of_data;
  assign key_ok  = (key_len != '0) && (key_len <= rbsf_pkg::KeyLenW'(KeyMax));
  assign match   = take && key_ok && (&hit);
  assign push    = match || (end_hit && !search_done);

  assign ctrl.shift = take;
  assign ctrl.clear = end_hit;

  // Window: a row of byte cells, newest byte in cell 0
  for (genvar j = 0; j < KeyMax; j++) begin : g_cell
    if (j == 0) begin : g_head
      rbsf_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .in_valid  (1'b1),
        .in_byte   (stream.data_byte),
        .key_byte  (aligned_key[j]),
        .en        (cell_en[j]),
        .out_valid (cell_v[j]),
        .out_byte  (cell_b[j]),
        .hit       (hit[j])
      );
    end else begin : g_body
      rbsf_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .in_valid  (cell_v[j-1]),
        .in_byte   (cell_b[j-1]),
        .key_byte  (aligned_key[j]),
        .en        (cell_en[j]),
        .out_valid (cell_v[j]),
        .out_byte  (cell_b[j]),
        .hit       (hit[j])
      );
    end
  end

  // Search state: set on a match, cleared by the end item
  always_ff @(posedge clk) begin
    if (rst) begin
      search_done <= 1'b0;
    end else if (end_hit) begin
      search_done <= 1'b0;
    end else if (match) begin
      search_done <= 1'b1;
    end
  end

  // Effective ring length
  assign buf_len = (buffer_size == '0 || buffer_size > rbsf_pkg::LenW'(rbsf_pkg::BufDepth))
                   ? rbsf_pkg::LenW'(rbsf_pkg::BufDepth) : buffer_size;

  // Result request: back offset is key_len-1, under 32 when matched
  always_comb begin
    req.found = match;
    req.index = stream.byte_index;
    req.back  = rbsf_pkg::BackW'(key_len - rbsf_pkg::KeyLenW'(1));
  end

  rbsf_wrap u_wrap (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .req     (req),
    .buf_len (buf_len),
    .ready   (wrap_ready),
    .result  (result)
  );

  assign stream.ready = wrap_ready;

  // No second match inside one search
  a_one_match: assert property (@(posedge clk) disable iff (rst)
    match |-> !search_done)
    else $error("match after search already done");

  // End item rearms the search and empties the window
  a_end_clear: assert property (@(posedge clk) disable iff (rst)
    end_hit |=> !search_done && !cell_v[0])
    else $error("end item did not clear the search");

  // Done flag only comes up through a match
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    $rose(search_done) |-> $past(match))
    else $error("search done without a match");

endmodule
